/* hdl/lfpd_pkg.sv */
// Package for the line-follow PD steering unit.
// Holds the microcode types, condition codes and register indexes shared by
// the sequencer and the top level. No dependencies.
package lfpd_pkg;

    // Datapath operations, one per microcode step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_MUL_KP,
        OP_MUL_E,
        OP_MUL_KD,
        OP_MUL_K1000,
        OP_ACC,
        OP_ABS,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CORR,
        OP_EMIT
    } op_t;

    // Jump conditions evaluated by the sequencer.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_VALID,
        COND_OUT_FREE,
        COND_CNT_NZ
    } cond_t;

    typedef logic [3:0] step_t;

    // One control word of the program.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  hold;
    } ucode_t;

    // Status from the datapath that the jump conditions look at.
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic cnt_nz;
    } seq_flags_t;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        op_t  op;
        logic fire;
    } seq_ctrl_t;

    typedef enum logic [2:0] {
        REG_CENTER_POSITION = 3'd0,
        REG_BASE_SPEED      = 3'd1,
        REG_DEAD_BAND       = 3'd2,
        REG_MAX_DUTY        = 3'd3,
        REG_KP_GAIN         = 3'd4,
        REG_KD_GAIN         = 3'd5,
        REG_LOST_THRESHOLD  = 3'd6,
        REG_SEARCH_OFFSET   = 3'd7
    } cfg_idx_t;

    localparam step_t STEP_IDLE = 4'd0;
    localparam step_t STEP_DIV  = 4'd8;
    localparam step_t STEP_EMIT = 4'd10;

endpackage

/* hdl/line_follow_pd_steering_unit.sv */
// Line-follow PD steering unit: a request is taken only while the unit is
// idle, so a new one waits until the previous result has been emitted.
// The microcode program runs five steps through one shared 32x17
// multiplier and adder, then an 8-step restoring divide loop.
// A result waiting in the output register does not block the next request.
// Reset (rst_n, asynchronous) loads the register defaults, clears the
// previous error and drops any pending result.
// Depends on lfpd_pkg and lfpd_sequencer.
module line_follow_pd_steering_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [12:0]        line_position,
    input  logic [9:0]         peak_reflectance,
    input  logic [15:0]        elapsed_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         left_duty,
    output logic               left_forward,
    output logic               left_reverse,
    output logic [7:0]         right_duty,
    output logic               right_forward,
    output logic               right_reverse,
    output logic signed [13:0] line_error,
    output logic               line_lost
);

    localparam logic signed [16:0] K_DERIV_SCALE = 17'sd1000;

    // Configuration registers
    logic [12:0] center_reg;
    logic [7:0]  base_reg;
    logic [12:0] dead_band_reg;
    logic [7:0]  max_duty_reg;
    logic [15:0] kp_reg;
    logic [15:0] kd_reg;
    logic [9:0]  lost_thr_reg;
    logic [7:0]  search_reg;

    // Datapath registers
    logic signed [13:0] err_reg;
    logic signed [13:0] prev_err_reg;
    logic [15:0]        e_reg;
    logic               lost_reg;
    logic signed [47:0] prod_reg;
    logic signed [47:0] acc_reg;
    logic               sign_reg;
    logic [34:0]        rem_reg;
    logic               sat_reg;
    logic [7:0]         quo_reg;
    logic [2:0]         cnt_reg;
    logic signed [9:0]  corr_reg;

    logic               out_valid_reg;
    logic [7:0]         left_reg;
    logic [7:0]         right_reg;
    logic signed [13:0] line_err_out_reg;
    logic               lost_out_reg;

    lfpd_pkg::seq_flags_t flags;
    lfpd_pkg::seq_ctrl_t  ctrl;

    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [14:0] diff;
    logic [47:0]        acc_abs;
    logic [23:0]        div_trial;
    logic               div_take;
    logic [8:0]         corr_mag;
    logic signed [9:0]  steer;
    logic signed [10:0] base_s;
    logic [13:0]        err_abs;
    logic               in_band;
    logic [7:0]         left_calc;
    logic [7:0]         right_calc;

    function automatic logic [7:0] clamp_duty(input logic signed [10:0] v,
                                              input logic [7:0] maxd);
        logic [7:0] r;
        priority if (v < 11'sd0)
            r = 8'd0;
        else if (v > $signed({3'b000, maxd}))
            r = maxd;
        else
            r = v[7:0];
        return r;
    endfunction

    lfpd_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign flags.in_valid = in_valid;
    assign flags.out_free = !out_valid_reg || out_ready;
    assign flags.cnt_nz   = (cnt_reg != 3'd0);
    assign in_ready       = (ctrl.op == lfpd_pkg::OP_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg    <= 13'd2500;
            base_reg      <= 8'd180;
            dead_band_reg <= 13'd400;
            max_duty_reg  <= 8'd255;
            kp_reg        <= 16'd492;
            kd_reg        <= 16'd3072;
            lost_thr_reg  <= 10'd80;
            search_reg    <= 8'd120;
        end
        else if (cfg_we)
        begin
            unique case (lfpd_pkg::cfg_idx_t'(cfg_index))
                lfpd_pkg::REG_CENTER_POSITION: center_reg    <= cfg_data[12:0];
                lfpd_pkg::REG_BASE_SPEED:      base_reg      <= cfg_data[7:0];
                lfpd_pkg::REG_DEAD_BAND:       dead_band_reg <= cfg_data[12:0];
                lfpd_pkg::REG_MAX_DUTY:        max_duty_reg  <= cfg_data[7:0];
                lfpd_pkg::REG_KP_GAIN:         kp_reg        <= cfg_data;
                lfpd_pkg::REG_KD_GAIN:         kd_reg        <= cfg_data;
                lfpd_pkg::REG_LOST_THRESHOLD:  lost_thr_reg  <= cfg_data[9:0];
                lfpd_pkg::REG_SEARCH_OFFSET:   search_reg    <= cfg_data[7:0];
                default:                       center_reg    <= center_reg;
            endcase
        end
    end

    // Shared multiplier; its operands follow the current step.
    always_comb
    begin
        diff = 15'({err_reg[13], err_reg} - {prev_err_reg[13], prev_err_reg});
        unique case (ctrl.op)
            lfpd_pkg::OP_MUL_KP:
            begin
                mul_a = 32'(err_reg);
                mul_b = $signed({1'b0, kp_reg});
            end
            lfpd_pkg::OP_MUL_E:
            begin
                mul_a = prod_reg[31:0];
                mul_b = $signed({1'b0, e_reg});
            end
            lfpd_pkg::OP_MUL_KD:
            begin
                mul_a = 32'(diff);
                mul_b = $signed({1'b0, kd_reg});
            end
            lfpd_pkg::OP_MUL_K1000:
            begin
                mul_a = prod_reg[31:0];
                mul_b = K_DERIV_SCALE;
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 17'sd0;
            end
        endcase
        mul_p = 49'(mul_a) * 49'(mul_b);
    end

    // Truncation toward zero is done on the magnitude, so the divide is
    // floor(floor(|num| / 4096) / e), one quotient bit per step.
    always_comb
    begin
        acc_abs   = acc_reg[47] ? 48'(-acc_reg) : 48'(acc_reg);
        div_trial = 24'({8'd0, e_reg} << cnt_reg);
        div_take  = (rem_reg >= {11'd0, div_trial});
        corr_mag  = sat_reg ? 9'd255 : {1'b0, quo_reg};
    end

    always_comb
    begin
        if (lost_reg)
            steer = prev_err_reg[13] ? -$signed({2'b00, search_reg})
                                     : $signed({2'b00, search_reg});
        else
            steer = corr_reg;
        base_s     = $signed({3'b000, base_reg});
        err_abs    = err_reg[13] ? 14'(-err_reg) : 14'(err_reg);
        in_band    = (err_abs <= {1'b0, dead_band_reg});
        if (!lost_reg && in_band)
        begin
            left_calc  = base_reg;
            right_calc = base_reg;
        end
        else
        begin
            left_calc  = clamp_duty(11'(base_s - 11'(steer)), max_duty_reg);
            right_calc = clamp_duty(11'(base_s + 11'(steer)), max_duty_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            unique case (ctrl.op)
                lfpd_pkg::OP_IDLE:
                begin
                    err_reg  <= 14'($signed({1'b0, center_reg})
                                    - $signed({1'b0, line_position}));
                    e_reg    <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
                    lost_reg <= (peak_reflectance < lost_thr_reg);
                end
                lfpd_pkg::OP_MUL_KP:    prod_reg <= mul_p[47:0];
                lfpd_pkg::OP_MUL_E:     acc_reg  <= mul_p[47:0];
                lfpd_pkg::OP_MUL_KD:    prod_reg <= mul_p[47:0];
                lfpd_pkg::OP_MUL_K1000: prod_reg <= mul_p[47:0];
                lfpd_pkg::OP_ACC:       acc_reg  <= 48'(acc_reg + prod_reg);
                lfpd_pkg::OP_ABS:
                begin
                    sign_reg <= acc_reg[47];
                    rem_reg  <= acc_abs[46:12];
                end
                lfpd_pkg::OP_DIV_INIT:
                begin
                    sat_reg <= (rem_reg >= {11'd0, e_reg, 8'd0});
                    quo_reg <= 8'd0;
                    cnt_reg <= 3'd7;
                end
                lfpd_pkg::OP_DIV_STEP:
                begin
                    if (div_take)
                        rem_reg <= rem_reg - {11'd0, div_trial};
                    quo_reg <= {quo_reg[6:0], div_take};
                    cnt_reg <= 3'(cnt_reg - 3'd1);
                end
                lfpd_pkg::OP_CORR:
                    corr_reg <= sign_reg ? -$signed({1'b0, corr_mag})
                                         : $signed({1'b0, corr_mag});
                lfpd_pkg::OP_EMIT:
                begin
                    left_reg         <= left_calc;
                    right_reg        <= right_calc;
                    line_err_out_reg <= err_reg;
                    lost_out_reg     <= lost_reg;
                end
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_err_reg  <= 14'sd0;
        end
        else
        begin
            if (ctrl.fire && ctrl.op == lfpd_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
                prev_err_reg  <= err_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_duty     = left_reg;
    assign left_forward  = (left_reg != 8'd0);
    assign left_reverse  = 1'b0;
    assign right_duty    = right_reg;
    assign right_forward = (right_reg != 8'd0);
    assign right_reverse = 1'b0;
    assign line_error    = line_err_out_reg;
    assign line_lost     = lost_out_reg;

endmodule

/* hdl/lfpd_sequencer.sv */
// Microcode sequencer for the line-follow PD steering unit.
// Holds the step counter and the program table; depends on lfpd_pkg.
module lfpd_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lfpd_pkg::seq_flags_t   flags,
    output lfpd_pkg::seq_ctrl_t    ctrl
);

    lfpd_pkg::step_t  pc_reg;
    lfpd_pkg::step_t  pc_next;
    lfpd_pkg::ucode_t cw;
    logic             cond_hit;

    function automatic lfpd_pkg::ucode_t rom(input lfpd_pkg::step_t addr);
        lfpd_pkg::ucode_t w;
        w = '{op: lfpd_pkg::OP_NOP, cond: lfpd_pkg::COND_ALWAYS,
              target: lfpd_pkg::STEP_IDLE, hold: 1'b0};
        unique case (addr)
            4'd0: w = '{lfpd_pkg::OP_IDLE, lfpd_pkg::COND_IN_VALID, 4'd1, 1'b1};
            4'd1: w = '{lfpd_pkg::OP_MUL_KP, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd2: w = '{lfpd_pkg::OP_MUL_E, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd3: w = '{lfpd_pkg::OP_MUL_KD, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd4: w = '{lfpd_pkg::OP_MUL_K1000, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd5: w = '{lfpd_pkg::OP_ACC, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd6: w = '{lfpd_pkg::OP_ABS, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd7: w = '{lfpd_pkg::OP_DIV_INIT, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd8: w = '{lfpd_pkg::OP_DIV_STEP, lfpd_pkg::COND_CNT_NZ,
                        lfpd_pkg::STEP_DIV, 1'b0};
            4'd9: w = '{lfpd_pkg::OP_CORR, lfpd_pkg::COND_NEVER, 4'd0, 1'b0};
            4'd10: w = '{lfpd_pkg::OP_EMIT, lfpd_pkg::COND_OUT_FREE,
                         lfpd_pkg::STEP_IDLE, 1'b1};
            default: w = '{lfpd_pkg::OP_NOP, lfpd_pkg::COND_ALWAYS,
                           lfpd_pkg::STEP_IDLE, 1'b0};
        endcase
        return w;
    endfunction

    always_comb
    begin
        cw = rom(pc_reg);
    end

    always_comb
    begin
        unique case (cw.cond)
            lfpd_pkg::COND_NEVER:    cond_hit = 1'b0;
            lfpd_pkg::COND_ALWAYS:   cond_hit = 1'b1;
            lfpd_pkg::COND_IN_VALID: cond_hit = flags.in_valid;
            lfpd_pkg::COND_OUT_FREE: cond_hit = flags.out_free;
            lfpd_pkg::COND_CNT_NZ:   cond_hit = flags.cnt_nz;
            default:                 cond_hit = 1'b1;
        endcase
    end

    // A held step waits in place and does nothing until its condition is met.
    always_comb
    begin
        priority if (cond_hit)
            pc_next = cw.target;
        else if (cw.hold)
            pc_next = pc_reg;
        else
            pc_next = 4'(pc_reg + 4'd1);
        ctrl.op   = cw.op;
        ctrl.fire = cond_hit || !cw.hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= lfpd_pkg::STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

/* tb/line_follow_pd_steering_checker.sv */
// Checker for the line-follow PD steering unit: tracks register writes,
// predicts each motor command from accepted samples and compares the results.
// Depends on lfpd_pkg.
module line_follow_pd_steering_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [12:0]        line_position,
    input  logic [9:0]         peak_reflectance,
    input  logic [15:0]        elapsed_ms,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [7:0]         left_duty,
    input  logic               left_forward,
    input  logic               left_reverse,
    input  logic [7:0]         right_duty,
    input  logic               right_forward,
    input  logic               right_reverse,
    input  logic signed [13:0] line_error,
    input  logic               line_lost,
    output int                 fail_count,
    output int                 outstanding,
    output int                 results_seen,
    output int                 lost_seen,
    output int                 coast_seen
);
    import lfpd_pkg::*;

    typedef struct packed {
        logic [7:0]         left_duty;
        logic               left_fwd;
        logic               left_rev;
        logic [7:0]         right_duty;
        logic               right_fwd;
        logic               right_rev;
        logic signed [13:0] err;
        logic               lost;
    } motor_cmd_t;

    logic [12:0]        center_reg;
    logic [7:0]         base_reg;
    logic [12:0]        dead_reg;
    logic [7:0]         maxd_reg;
    logic [15:0]        kp_reg;
    logic [15:0]        kd_reg;
    logic [9:0]         lost_thr_reg;
    logic [7:0]         search_reg;
    logic signed [13:0] prev_err;

    motor_cmd_t pending_cmds[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Works out the motor command for one sample and advances the stored error.
    function automatic motor_cmd_t predict_drive(logic [12:0] pos, logic [9:0] peak,
                                                 logic [15:0] ms);
        longint     e;
        longint     err;
        longint     num;
        longint     corr;
        longint     mag;
        longint     left;
        longint     right;
        longint     off;
        motor_cmd_t cmd;
        e = (ms == 16'd0) ? 64'sd1 : longint'(ms);
        err = longint'(center_reg) - longint'(pos);
        num = longint'(kp_reg) * err * e
            + longint'(kd_reg) * (err - longint'(prev_err)) * 1000;
        corr = clamp(num / (4096 * e), -255, 255);
        mag = (err < 0) ? -err : err;
        if (mag <= longint'(dead_reg))
        begin
            left = longint'(base_reg);
            right = longint'(base_reg);
        end
        else
        begin
            left = clamp(longint'(base_reg) - corr, 0, longint'(maxd_reg));
            right = clamp(longint'(base_reg) + corr, 0, longint'(maxd_reg));
        end
        cmd.lost = (peak < lost_thr_reg);
        if (cmd.lost)
        begin
            // Search turns toward the side where the line was last seen.
            off = (prev_err < 0) ? -longint'(search_reg) : longint'(search_reg);
            left = clamp(longint'(base_reg) - off, 0, longint'(maxd_reg));
            right = clamp(longint'(base_reg) + off, 0, longint'(maxd_reg));
        end
        prev_err = err[13:0];
        cmd.left_duty = left[7:0];
        cmd.left_fwd = (left != 0);
        cmd.left_rev = 1'b0;
        cmd.right_duty = right[7:0];
        cmd.right_fwd = (right != 0);
        cmd.right_rev = 1'b0;
        cmd.err = err[13:0];
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        motor_cmd_t got;
        motor_cmd_t want;
        if (!rst_n)
        begin
            center_reg = 13'd2500;
            base_reg = 8'd180;
            dead_reg = 13'd400;
            maxd_reg = 8'd255;
            kp_reg = 16'd492;
            kd_reg = 16'd3072;
            lost_thr_reg = 10'd80;
            search_reg = 8'd120;
            prev_err = '0;
            pending_cmds.delete();
            fail_count = 0;
            results_seen = 0;
            lost_seen = 0;
            coast_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_CENTER_POSITION: center_reg = cfg_data[12:0];
                    REG_BASE_SPEED:      base_reg = cfg_data[7:0];
                    REG_DEAD_BAND:       dead_reg = cfg_data[12:0];
                    REG_MAX_DUTY:        maxd_reg = cfg_data[7:0];
                    REG_KP_GAIN:         kp_reg = cfg_data;
                    REG_KD_GAIN:         kd_reg = cfg_data;
                    REG_LOST_THRESHOLD:  lost_thr_reg = cfg_data[9:0];
                    REG_SEARCH_OFFSET:   search_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                pending_cmds.push_back(predict_drive(line_position, peak_reflectance,
                                                     elapsed_ms));
            if (out_valid && out_ready)
            begin
                got = {left_duty, left_forward, left_reverse, right_duty,
                       right_forward, right_reverse, line_error, line_lost};
                if (pending_cmds.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result with no request pending: L=%0d R=%0d err=%0d",
                                 left_duty, right_duty, line_error);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    results_seen++;
                    if (want.lost)
                        lost_seen++;
                    if (want.left_duty == 8'd0 || want.right_duty == 8'd0)
                        coast_seen++;
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("Mismatch on result %0d:", results_seen);
                            $display("  expected L=%0d/%b%b R=%0d/%b%b err=%0d lost=%b",
                                     want.left_duty, want.left_fwd, want.left_rev,
                                     want.right_duty, want.right_fwd, want.right_rev,
                                     want.err, want.lost);
                            $display("  got      L=%0d/%b%b R=%0d/%b%b err=%0d lost=%b",
                                     got.left_duty, got.left_fwd, got.left_rev,
                                     got.right_duty, got.right_fwd, got.right_rev,
                                     got.err, got.lost);
                        end
                    end
                end
            end
            outstanding <= pending_cmds.size();
        end
    end

endmodule

/* tb/line_follow_pd_steering_unit_tb.sv */
// Testbench top for the line-follow PD steering unit: clock, reset, register
// settings, sample requests and result back-pressure, plus the final verdict.
// Depends on lfpd_pkg, line_follow_pd_steering_unit and the steering checker.
module line_follow_pd_steering_unit_tb;
    import lfpd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;

    typedef struct {
        logic [12:0] center;
        logic [7:0]  base;
        logic [12:0] dead;
        logic [7:0]  maxd;
        logic [15:0] kp;
        logic [15:0] kd;
        logic [9:0]  lost_thr;
        logic [7:0]  search;
    } steer_cfg_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [12:0]        line_position;
    logic [9:0]         peak_reflectance;
    logic [15:0]        elapsed_ms;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         left_duty;
    logic               left_forward;
    logic               left_reverse;
    logic [7:0]         right_duty;
    logic               right_forward;
    logic               right_reverse;
    logic signed [13:0] line_error;
    logic               line_lost;

    int fail_count;
    int outstanding;
    int results_seen;
    int lost_seen;
    int coast_seen;

    int cycle_count = 0;
    int samples_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_req_id = 0;
    int hold_ack_id = 0;
    int hold_left = 0;

    line_follow_pd_steering_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .line_position    (line_position),
        .peak_reflectance (peak_reflectance),
        .elapsed_ms       (elapsed_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_duty        (left_duty),
        .left_forward     (left_forward),
        .left_reverse     (left_reverse),
        .right_duty       (right_duty),
        .right_forward    (right_forward),
        .right_reverse    (right_reverse),
        .line_error       (line_error),
        .line_lost        (line_lost)
    );

    line_follow_pd_steering_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .line_position    (line_position),
        .peak_reflectance (peak_reflectance),
        .elapsed_ms       (elapsed_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_duty        (left_duty),
        .left_forward     (left_forward),
        .left_reverse     (left_reverse),
        .right_duty       (right_duty),
        .right_forward    (right_forward),
        .right_reverse    (right_reverse),
        .line_error       (line_error),
        .line_lost        (line_lost),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .results_seen     (results_seen),
        .lost_seen        (lost_seen),
        .coast_seen       (coast_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_req_id != hold_ack_id)
        begin
            hold_ack_id <= hold_req_id;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(input logic [12:0] pos, input logic [9:0] peak,
                               input logic [15:0] ms);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        line_position <= pos;
        peak_reflectance <= peak;
        elapsed_ms <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_random_sample();
        logic [12:0] pos;
        logic [9:0]  peak;
        logic [15:0] ms;
        int          r;
        r = $urandom_range(99);
        if (r < 40)
            pos = 13'($urandom_range(3100, 1900));
        else if (r < 90)
            pos = 13'($urandom_range(5000, 0));
        else
            pos = 13'($urandom_range(8191, 0));
        r = $urandom_range(99);
        if (r < 75)
            peak = 10'($urandom_range(1000, 100));
        else if (r < 92)
            peak = 10'($urandom_range(120, 0));
        else
            peak = 10'($urandom_range(1023, 0));
        r = $urandom_range(99);
        if (r < 55)
            ms = 16'($urandom_range(30, 1));
        else if (r < 65)
            ms = 16'd0;
        else if (r < 88)
            ms = 16'($urandom_range(1000, 0));
        else
            ms = 16'($urandom_range(65535, 0));
        send_sample(pos, peak, ms);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input steer_cfg_t s);
        write_reg(REG_CENTER_POSITION, 16'(s.center));
        write_reg(REG_BASE_SPEED, 16'(s.base));
        write_reg(REG_DEAD_BAND, 16'(s.dead));
        write_reg(REG_MAX_DUTY, 16'(s.maxd));
        write_reg(REG_KP_GAIN, s.kp);
        write_reg(REG_KD_GAIN, s.kd);
        write_reg(REG_LOST_THRESHOLD, 16'(s.lost_thr));
        write_reg(REG_SEARCH_OFFSET, 16'(s.search));
        cfg_we <= 1'b0;
    endtask

    function automatic steer_cfg_t phase_settings(int phase);
        steer_cfg_t s;
        case (phase)
            0: s = '{13'd2500, 8'd180, 13'd400, 8'd255, 16'd492, 16'd3072, 10'd80, 8'd120};
            1: s = '{13'd0, 8'd0, 13'd0, 8'd0, 16'd0, 16'd0, 10'd0, 8'd0};
            2: s = '{13'd5000, 8'd255, 13'd5000, 8'd255, 16'd65535, 16'd65535, 10'd1000,
                     8'd255};
            4: s = '{13'd8191, 8'd255, 13'd0, 8'd128, 16'd65535, 16'd0, 10'd1023, 8'd0};
            5: s = '{13'd2500, 8'd128, 13'd0, 8'd200, 16'd20000, 16'd8000, 10'd500, 8'd200};
            default:
            begin
                s.center = 13'($urandom_range(phase == 3 ? 5000 : 8191, 0));
                s.base = 8'($urandom_range(255, 0));
                s.dead = 13'($urandom_range(phase == 3 ? 1500 : 8191, 0));
                s.maxd = 8'($urandom_range(255, 0));
                s.kp = 16'($urandom_range(65535, 0));
                s.kd = 16'($urandom_range(65535, 0));
                s.lost_thr = 10'($urandom_range(phase == 3 ? 300 : 1023, 0));
                s.search = 8'($urandom_range(255, 0));
            end
        endcase
        return s;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CENTER_POSITION;
        cfg_data = '0;
        in_valid = 1'b0;
        line_position = '0;
        peak_reflectance = '0;
        elapsed_ms = '0;
        out_ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset settings: dead band edges, hard swings
        // that saturate the correction, zero and maximum elapsed time, and the
        // lost-line search after positive, negative and zero errors.
        send_sample(13'd2500, 10'd1000, 16'd10);
        send_sample(13'd2100, 10'd1000, 16'd10);
        send_sample(13'd2099, 10'd1000, 16'd10);
        send_sample(13'd2900, 10'd1000, 16'd10);
        send_sample(13'd2901, 10'd1000, 16'd10);
        send_sample(13'd0, 10'd1000, 16'd1);
        send_sample(13'd5000, 10'd1000, 16'd1);
        send_sample(13'd5000, 10'd1000, 16'd0);
        send_sample(13'd8191, 10'd1023, 16'd65535);
        send_sample(13'd0, 10'd1023, 16'd65535);
        send_sample(13'd1000, 10'd79, 16'd10);
        send_sample(13'd4000, 10'd80, 16'd10);
        send_sample(13'd4000, 10'd0, 16'd10);
        send_sample(13'd2500, 10'd0, 16'd10);
        send_sample(13'd2500, 10'd40, 16'd10);
        send_sample(13'd1500, 10'd1000, 16'd100);
        send_sample(13'd3500, 10'd1000, 16'd100);
        send_sample(13'd2500, 10'd1000, 16'd65535);
        send_sample(13'd0, 10'd0, 16'd0);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
                default: begin send_idle_pct = 16; recv_stall_pct <= 16; end
            endcase
            apply_settings(phase_settings(phase));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // The result side holds off long enough for the unit to fill up
                // and refuse requests while samples keep coming.
                if (phase == 0 && n == 20)
                begin
                    hold_len <= 400;
                    hold_req_id <= hold_req_id + 1;
                end
                if (phase == 1 && n == 70)
                    drain();
                send_random_sample();
            end
            drain();
        end

        repeat (40) @(posedge clk);
        $display("Sent %0d samples over %0d register settings; checked %0d results,",
                 samples_sent, PHASES + 1, results_seen);
        $display("%0d of them with the line lost and %0d with a coasting motor.",
                 lost_seen, coast_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
